/* rtl/core/mbq_pkg.sv */
// Shared types, widths and register codes of the multichannel biquad filter.
package mbq_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CHAN_BITS    = 3;
   localparam int SAMPLE_BITS  = 24;
   localparam int COEF_BITS    = 32;
   localparam int COEF_FRAC    = COEF_BITS - 4;
   localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS     = PROD_BITS + 3;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CHAN_BITS:0]          CHAN_COUNT = (CHAN_BITS + 1)'(NUM_CHANNELS);
   localparam logic signed [COEF_BITS-1:0] COEF_ONE   = COEF_BITS'(64'd1 << COEF_FRAC);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FF0 = 3'd0,
      CSR_FF1 = 3'd1,
      CSR_FF2 = 3'd2,
      CSR_FB1 = 3'd3,
      CSR_FB2 = 3'd4,
      CSR_WET = 3'd5,
      CSR_DRY = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic [CHAN_BITS-1:0]          chan;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic [CHAN_BITS-1:0]          chan_out;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x0;
      logic [CHAN_BITS-1:0]          chan;
      logic                          chan_ok;
   } item_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] ff0;
      logic signed [COEF_BITS-1:0] ff1;
      logic signed [COEF_BITS-1:0] ff2;
      logic signed [COEF_BITS-1:0] fb1;
      logic signed [COEF_BITS-1:0] fb2;
      logic signed [COEF_BITS-1:0] wet;
      logic signed [COEF_BITS-1:0] dry;
   } coef_type;

endpackage

/* rtl/core/multichannel_biquad_filter.sv */
// Top level of the multichannel biquad filter: front queue, engine, coefficient registers.
// Direct form I biquad over eight channel histories, with optional wet/dry mix. A word
// pushed on req_ is queued two deep, then run through one shared 32x24 multiplier: five
// products, a drain step, a round/saturate step and a handoff step, plus two mix products,
// a drain and a round when the dry coefficient is nonzero. The engine works on one word at a
// time since each word updates its channel's history; the front queue and the result
// register let both sides stall independently. Coefficients are Q3.28 and should be
// written only while the block is idle; csr_ready is always high.
module multichannel_biquad_filter
   import mbq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  req_type                 req_word,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output rsp_type                 rsp_word,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]    csr_data
);

   coef_type    coef;
   item_type    item;
   logic        item_valid;
   logic        item_take;
   logic        eng_busy;

   mbq_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   mbq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_word   (req_word),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take)
   );

   mbq_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .busy       (eng_busy),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_word   (rsp_word)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      item_take |-> item_valid)
      else $error("engine took a word from an empty front queue");

   a_result_from_engine: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(eng_busy))
      else $error("result appeared without engine activity");

   a_take_when_idle: assert property (@(posedge clock) disable iff (reset)
      item_take |=> eng_busy)
      else $error("engine did not start after taking a word");

endmodule

/* rtl/core/mbq_regs.sv */
// Coefficient register file written through the configuration port.
module mbq_regs
   import mbq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]    csr_data,
   output coef_type                coef
);

   coef_type coef_ff;
   coef_type coef_in;

   assign csr_ready = 1'b1;
   assign coef      = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FF0: coef_in.ff0 = csr_data;
            CSR_FF1: coef_in.ff1 = csr_data;
            CSR_FF2: coef_in.ff2 = csr_data;
            CSR_FB1: coef_in.fb1 = csr_data;
            CSR_FB2: coef_in.fb2 = csr_data;
            CSR_WET: coef_in.wet = csr_data;
            CSR_DRY: coef_in.dry = csr_data;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff     <= '0;
         coef_ff.ff0 <= COEF_ONE;
         coef_ff.wet <= COEF_ONE;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

/* rtl/core/mbq_front.sv */
// Input side: accepts request words, tags channel range, queues them for the engine.
module mbq_front
   import mbq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   output logic     req_full,
   input  req_type  req_word,
   output item_type item,
   output logic     item_valid,
   input  logic     item_take
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push_ok;
   logic       pop_ok;
   item_type   entry;

   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_take && item_valid;

   always_comb begin
      entry.x0      = req_word.sample_in;
      entry.chan    = req_word.chan;
      entry.chan_ok = ({1'b0, req_word.chan} < CHAN_COUNT);
      wr_ptr_in     = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in     = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in      = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

/* rtl/core/mbq_engine.sv */
// Filter engine: shared multiply-accumulate sequencer, channel histories, result register.
module mbq_engine
   import mbq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  coef_type coef,
   input  item_type item,
   input  logic     item_valid,
   output logic     item_take,
   output logic     busy,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_word
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MAC   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   localparam logic [2:0] TAP_X0   = 3'd0;
   localparam logic [2:0] TAP_X1   = 3'd1;
   localparam logic [2:0] TAP_X2   = 3'd2;
   localparam logic [2:0] TAP_Y1   = 3'd3;
   localparam logic [2:0] TAP_Y2   = 3'd4;
   localparam logic [2:0] TAP_WET  = 3'd0;
   localparam logic [2:0] TAP_DRY  = 3'd1;

   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(64'd1 << (COEF_FRAC - 1));
   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [ACC_BITS-1:0] SAT_LO = -(ACC_BITS'(64'd1 << (SAMPLE_BITS - 1)));

   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
      input logic signed [ACC_BITS-1:0] acc
   );
      logic signed [ACC_BITS-1:0] r;
      logic signed [ACC_BITS-1:0] q;
      r = acc + ROUND_HALF;
      q = r >>> COEF_FRAC;
      if (q > SAT_HI) begin
         q = SAT_HI;
      end else if (q < SAT_LO) begin
         q = SAT_LO;
      end
      return q[SAMPLE_BITS-1:0];
   endfunction

   state_type                     state_ff, state_in;
   logic [2:0]                    cnt_ff, cnt_in;
   logic                          mix_ff, mix_in;
   logic                          pv_ff, pv_in;
   logic                          neg_ff, neg_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] x0_ff, x0_in;
   logic signed [SAMPLE_BITS-1:0] x1_ff, x1_in;
   logic signed [SAMPLE_BITS-1:0] x2_ff, x2_in;
   logic signed [SAMPLE_BITS-1:0] y1_ff, y1_in;
   logic signed [SAMPLE_BITS-1:0] y2_ff, y2_in;
   logic signed [SAMPLE_BITS-1:0] y0_ff, y0_in;
   logic signed [SAMPLE_BITS-1:0] res_ff, res_in;
   logic [CHAN_BITS-1:0]          chan_ff, chan_in;
   logic                          ok_ff, ok_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_word_ff, rsp_word_in;

   logic signed [SAMPLE_BITS-1:0] in_hist1_ff  [NUM_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] in_hist2_ff  [NUM_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] out_hist1_ff [NUM_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] out_hist2_ff [NUM_CHANNELS];

   logic signed [COEF_BITS-1:0]   mul_coef;
   logic signed [SAMPLE_BITS-1:0] mul_op;
   logic                          mul_neg;
   logic signed [ACC_BITS-1:0]    prod_ext;
   logic signed [ACC_BITS-1:0]    acc_sum;
   logic signed [SAMPLE_BITS-1:0] rnd;
   logic [2:0]                    last_tap;
   logic                          hist_we;
   logic                          pop_ok;
   logic                          load_rsp;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign pop_ok    = rsp_pop && rsp_valid_ff;
   assign prod_ext  = {{(ACC_BITS - PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};
   assign rnd       = round_sat(acc_ff);
   assign last_tap  = mix_ff ? TAP_DRY : TAP_Y2;

   always_comb begin
      mul_coef = coef.ff0;
      mul_op   = x0_ff;
      mul_neg  = 1'b0;
      if (mix_ff) begin
         case (cnt_ff)
            TAP_WET: begin
               mul_coef = coef.wet;
               mul_op   = y0_ff;
            end
            default: begin
               mul_coef = coef.dry;
               mul_op   = x0_ff;
            end
         endcase
      end else begin
         case (cnt_ff)
            TAP_X0: begin
               mul_coef = coef.ff0;
               mul_op   = x0_ff;
            end
            TAP_X1: begin
               mul_coef = coef.ff1;
               mul_op   = x1_ff;
            end
            TAP_X2: begin
               mul_coef = coef.ff2;
               mul_op   = x2_ff;
            end
            TAP_Y1: begin
               mul_coef = coef.fb1;
               mul_op   = y1_ff;
               mul_neg  = 1'b1;
            end
            TAP_Y2: begin
               mul_coef = coef.fb2;
               mul_op   = y2_ff;
               mul_neg  = 1'b1;
            end
            default: begin
               mul_coef = coef.ff0;
               mul_op   = x0_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (!pv_ff) begin
         acc_sum = acc_ff;
      end else if (neg_ff) begin
         acc_sum = acc_ff - prod_ext;
      end else begin
         acc_sum = acc_ff + prod_ext;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      mix_in      = mix_ff;
      pv_in       = pv_ff;
      neg_in      = neg_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      x0_in       = x0_ff;
      x1_in       = x1_ff;
      x2_in       = x2_ff;
      y1_in       = y1_ff;
      y2_in       = y2_ff;
      y0_in       = y0_ff;
      res_in      = res_ff;
      chan_in     = chan_ff;
      ok_in       = ok_ff;
      item_take   = 1'b0;
      hist_we     = 1'b0;
      load_rsp    = 1'b0;
      rsp_word_in = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               x0_in     = item.x0;
               chan_in   = item.chan;
               ok_in     = item.chan_ok;
               x1_in     = item.chan_ok ? in_hist1_ff[item.chan] : '0;
               x2_in     = item.chan_ok ? in_hist2_ff[item.chan] : '0;
               y1_in     = item.chan_ok ? out_hist1_ff[item.chan] : '0;
               y2_in     = item.chan_ok ? out_hist2_ff[item.chan] : '0;
               acc_in    = '0;
               pv_in     = 1'b0;
               cnt_in    = TAP_X0;
               mix_in    = 1'b0;
               state_in  = ST_MAC;
            end
         end
         ST_MAC: begin
            prod_in = mul_coef * mul_op;
            neg_in  = mul_neg;
            pv_in   = 1'b1;
            acc_in  = acc_sum;
            if (cnt_ff == last_tap) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            acc_in   = acc_sum;
            pv_in    = 1'b0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (!mix_ff) begin
               y0_in   = rnd;
               hist_we = ok_ff;
               if (coef.dry != '0) begin
                  mix_in   = 1'b1;
                  cnt_in   = TAP_WET;
                  acc_in   = '0;
                  pv_in    = 1'b0;
                  state_in = ST_MAC;
               end else begin
                  res_in   = rnd;
                  state_in = ST_DONE;
               end
            end else begin
               res_in   = rnd;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || pop_ok) begin
               load_rsp               = 1'b1;
               rsp_word_in.sample_out = res_ff;
               rsp_word_in.chan_out   = chan_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (pop_ok) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= TAP_X0;
         mix_ff       <= 1'b0;
         pv_ff        <= 1'b0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            in_hist1_ff[i]  <= '0;
            in_hist2_ff[i]  <= '0;
            out_hist1_ff[i] <= '0;
            out_hist2_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mix_ff       <= mix_in;
         pv_ff        <= pv_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (hist_we) begin
            in_hist2_ff[chan_ff]  <= x1_ff;
            in_hist1_ff[chan_ff]  <= x0_ff;
            out_hist2_ff[chan_ff] <= y1_ff;
            out_hist1_ff[chan_ff] <= rnd;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      y1_ff       <= y1_in;
      y2_ff       <= y2_in;
      y0_ff       <= y0_in;
      res_ff      <= res_in;
      chan_ff     <= chan_in;
      ok_ff       <= ok_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

/* sim/tb.sv */
// Testbench for the multichannel biquad filter: queued stimulus, predictor and result checks.
module tb;
   import mbq_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0]      CSR_UNUSED = CSR_IDX_BITS'(7);
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   req_type                 req_word = '0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   rsp_type                 rsp_word;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [COEF_BITS-1:0]    csr_data = '0;

   multichannel_biquad_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Filter copy: coefficients and per-channel histories.
   coef_type                      coefs;
   logic signed [SAMPLE_BITS-1:0] x_hist1 [NUM_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] x_hist2 [NUM_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y_hist1 [NUM_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y_hist2 [NUM_CHANNELS];

   req_type pending_words [$];
   rsp_type predicted_out [$];
   int      words_queued = 0;
   int      words_accepted = 0;
   int      results_checked = 0;
   int      mismatches = 0;
   int      coef_sets = 0;
   int      mix_sets = 0;
   int      burst_left = 0;
   int      gap_left = 0;
   int      pop_left = 0;
   int      stall_left = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic signed [SAMPLE_BITS-1:0] round_clamp(longint acc);
      longint q;
      q = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (q > longint'(SAMPLE_MAX)) q = longint'(SAMPLE_MAX);
      if (q < longint'(SAMPLE_MIN)) q = longint'(SAMPLE_MIN);
      return SAMPLE_BITS'(q);
   endfunction

   function automatic rsp_type filter_word(req_type w);
      longint                        x0, x1, x2, y1, y2, acc;
      logic signed [SAMPLE_BITS-1:0] y0;
      bit                            in_range;
      rsp_type                       r;
      in_range = int'(w.chan) < NUM_CHANNELS;
      x0 = longint'(signed'(w.sample_in));
      x1 = 0;
      x2 = 0;
      y1 = 0;
      y2 = 0;
      if (in_range) begin
         x1 = longint'(x_hist1[w.chan]);
         x2 = longint'(x_hist2[w.chan]);
         y1 = longint'(y_hist1[w.chan]);
         y2 = longint'(y_hist2[w.chan]);
      end
      acc = longint'(coefs.ff0) * x0 + longint'(coefs.ff1) * x1 + longint'(coefs.ff2) * x2
          - longint'(coefs.fb1) * y1 - longint'(coefs.fb2) * y2;
      y0 = round_clamp(acc);
      if (in_range) begin
         x_hist2[w.chan] = x_hist1[w.chan];
         x_hist1[w.chan] = w.sample_in;
         y_hist2[w.chan] = y_hist1[w.chan];
         y_hist1[w.chan] = y0;
      end
      if (coefs.dry != 0)
         r.sample_out = round_clamp(longint'(coefs.wet) * longint'(y0)
                                    + longint'(coefs.dry) * x0);
      else
         r.sample_out = y0;
      r.chan_out = w.chan;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint want, longint got);
      $display("MISMATCH %s on result %0d: expected %0d, got %0d",
               what, results_checked, want, got);
      mismatches++;
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FF0: coefs.ff0 = data;
         CSR_FF1: coefs.ff1 = data;
         CSR_FF2: coefs.ff2 = data;
         CSR_FB1: coefs.fb1 = data;
         CSR_FB2: coefs.fb2 = data;
         CSR_WET: coefs.wet = data;
         CSR_DRY: coefs.dry = data;
         default: ;
      endcase
   endtask

   task automatic queue_word(logic signed [SAMPLE_BITS-1:0] s, logic [CHAN_BITS-1:0] ch);
      req_type w;
      w.sample_in = s;
      w.chan      = ch;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (words_accepted != words_queued || predicted_out.size() != 0);
      repeat (16) @(negedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin : driver
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predicted_out.push_back(filter_word(req_word));
            words_accepted++;
         end
         if (!(req_push && req_full)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_push <= 1'b1;
               req_word <= pending_words.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  if ($urandom_range(0, 2) == 0)
                     gap_left = 0;
                  else if ($urandom_range(0, 5) == 0)
                     gap_left = $urandom_range(20, 60);
                  else
                     gap_left = $urandom_range(1, 12);
               end
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Receiver: runs of pops broken by stalls of random length.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (predicted_out.size() == 0) begin
               report_mismatch("unexpected word", 0, longint'(signed'(rsp_word.sample_out)));
            end else begin
               want = predicted_out.pop_front();
               if (rsp_word.sample_out !== want.sample_out)
                  report_mismatch("sample_out", longint'(signed'(want.sample_out)),
                                  longint'(signed'(rsp_word.sample_out)));
               if (rsp_word.chan_out !== want.chan_out)
                  report_mismatch("chan_out", longint'(want.chan_out),
                                  longint'(rsp_word.chan_out));
            end
            results_checked++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (pop_left > 0) begin
               pop_left--;
            end else begin
               pop_left   = $urandom_range(0, 30);
               stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
            end
         end
      end
   end

   initial begin : stimulus
      logic signed [SAMPLE_BITS-1:0] s;
      logic signed [COEF_BITS-1:0]   c;
      logic [CHAN_BITS-1:0]          ch;
      bit                            mix;
      coefs.ff0 = COEF_ONE;
      coefs.ff1 = '0;
      coefs.ff2 = '0;
      coefs.fb1 = '0;
      coefs.fb2 = '0;
      coefs.wet = COEF_ONE;
      coefs.dry = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         x_hist1[i] = '0;
         x_hist2[i] = '0;
         y_hist1[i] = '0;
         y_hist2[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients: pass-through, sample extremes, every channel.
      @(negedge clock);
      queue_word(SAMPLE_MAX, 0);
      queue_word(SAMPLE_MIN, 1);
      queue_word('0, 2);
      queue_word(-1, 3);
      queue_word(1, 4);
      queue_word(SAMPLE_MAX, 5);
      queue_word(SAMPLE_MIN, 6);
      queue_word(SAMPLE_BITS'(24'h555555), 7);
      queue_word(SAMPLE_BITS'(24'h2AAAAA), 0);
      coef_sets++;
      wait_drained();

      // Extreme coefficients: drive y0 into both saturation limits.
      csr_write(CSR_FF0, COEF_MAX);
      csr_write(CSR_FF1, COEF_MIN);
      csr_write(CSR_FF2, COEF_ONE);
      csr_write(CSR_FB1, COEF_MIN);
      csr_write(CSR_FB2, COEF_MAX);
      csr_write(CSR_WET, COEF_MAX);
      @(negedge clock);
      queue_word(SAMPLE_MAX, 0);
      queue_word(SAMPLE_MIN, 0);
      queue_word(SAMPLE_MAX, 0);
      queue_word(1, 3);
      queue_word(-1, 3);
      coef_sets++;
      wait_drained();

      // Dry mix on, plus a write to an unused register index.
      csr_write(CSR_DRY, COEF_MIN);
      csr_write(CSR_WET, COEF_ONE >>> 1);
      csr_write(CSR_UNUSED, 32'hA5A5_5A5A);
      @(negedge clock);
      queue_word(SAMPLE_MAX, 1);
      queue_word(SAMPLE_MIN, 1);
      queue_word('0, 1);
      queue_word(SAMPLE_MAX, 2);
      queue_word(SAMPLE_MIN, 7);
      coef_sets++;
      mix_sets++;
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         mix = phase[0];
         for (int r = int'(CSR_FF0); r <= int'(CSR_DRY); r++) begin
            case ($urandom_range(0, 4))
               0:       c = $urandom;
               1:       c = COEF_BITS'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
               2:       c = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
               3:       c = '0;
               default: c = COEF_ONE;
            endcase
            if (r == int'(CSR_DRY)) begin
               if (!mix) c = '0;
               else if (c == 0) c = COEF_ONE;
            end
            csr_write(CSR_IDX_BITS'(r), c);
         end
         if ($urandom_range(0, 1) == 0) csr_write(CSR_UNUSED, $urandom);
         coef_sets++;
         if (mix) mix_sets++;
         @(negedge clock);
         ch = CHAN_BITS'($urandom_range(0, NUM_CHANNELS - 1));
         for (int n = 0; n < 250; n++) begin
            case ($urandom_range(0, 3))
               0:       s = SAMPLE_BITS'($urandom);
               1:       s = SAMPLE_BITS'(int'($urandom_range(0, 8192)) - 4096);
               2:       s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
               default: s = SAMPLE_BITS'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            endcase
            if ($urandom_range(0, 3) != 0) ch = CHAN_BITS'($urandom_range(0, NUM_CHANNELS - 1));
            queue_word(s, ch);
         end
         wait_drained();
      end

      repeat (40) @(posedge clock);
      $display("Checked %0d results from %0d words across %0d coefficient sets",
               results_checked, words_accepted, coef_sets);
      $display("%0d of those sets mixed in the dry input", mix_sets);
      if (mismatches == 0 && predicted_out.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin : watchdog
      #24000000;
      $display("Timeout with %0d results still expected", predicted_out.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
